/* sv/rcmm_pkg.sv */
// ----------------------------------------------------------------------------
// rcmm_pkg
// shared field widths and codes of the rod cutting max/min table block
// ----------------------------------------------------------------------------
`default_nettype none

package rcmm_pkg;

  // item field widths
  localparam int KIND_W  = 1;
  localparam int IDX_W   = 4;
  localparam int PRICE_W = 10;
  localparam int ROD_W   = 5;

  // result field widths
  localparam int RKIND_W = 2;
  localparam int TOTAL_W = 15;
  localparam int PIECE_W = 4;

  // common width for length and piece compares
  localparam int CMP_W = ROD_W + 1;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
  localparam logic [KIND_W-1:0] KIND_RUN  = 1'b1;

  // result kinds
  localparam logic [RKIND_W-1:0] RES_TOTALS    = 2'd0;
  localparam logic [RKIND_W-1:0] RES_MAX_PIECE = 2'd1;
  localparam logic [RKIND_W-1:0] RES_MIN_PIECE = 2'd2;

endpackage

`default_nettype wire

/* sv/rcmm_item_if.sv */
// ----------------------------------------------------------------------------
// rcmm_item_if
// input channel: price loads and run requests with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface rcmm_item_if;

  logic                              valid;
  logic                              ready;
  logic [rcmm_pkg::KIND_W-1:0]       kind;
  logic [rcmm_pkg::IDX_W-1:0]        piece_index;
  logic [rcmm_pkg::PRICE_W-1:0]      price_value;
  logic [rcmm_pkg::ROD_W-1:0]        rod_length;

  modport source (
    output valid, kind, piece_index, price_value, rod_length,
    input  ready
  );

  modport sink (
    input  valid, kind, piece_index, price_value, rod_length,
    output ready
  );

endinterface

`default_nettype wire

/* sv/rcmm_result_if.sv */
// ----------------------------------------------------------------------------
// rcmm_result_if
// output channel: totals and cut pieces with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface rcmm_result_if;

  logic                              valid;
  logic                              ready;
  logic [rcmm_pkg::RKIND_W-1:0]      result_kind;
  logic [rcmm_pkg::TOTAL_W-1:0]      max_total;
  logic [rcmm_pkg::TOTAL_W-1:0]      min_total;
  logic [rcmm_pkg::PIECE_W-1:0]      piece_length;
  logic                              last;

  modport source (
    output valid, result_kind, max_total, min_total, piece_length, last,
    input  ready
  );

  modport sink (
    input  valid, result_kind, max_total, min_total, piece_length, last,
    output ready
  );

endinterface

`default_nettype wire

/* sv/rcmm_mem.sv */
// ----------------------------------------------------------------------------
// rcmm_mem
// simple dual port table memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rcmm_mem #(
  parameter int DEPTH  = 32,
  parameter int WIDTH  = 38,
  parameter int ADDR_W = 5
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/rod_cut_max_min_table.sv */
// ----------------------------------------------------------------------------
// rod_cut_max_min_table
// bottom-up rod cutting: highest and lowest total price with both cuts
// ----------------------------------------------------------------------------
// timing: a load is taken in S_IDLE; a run of length n fills the tables length
//   by length, one table read per candidate and one row write per length,
//   then sends the totals and each piece, every piece with a read and a wait
// throughput: one item at a time; no new item is taken until a run's last
//   result is loaded, and the receiver holding off stretches the run
// reset: rst clears control and the price table; the total/choice tables
//   need no clearing since every run writes lengths 1..n before reading them
// ----------------------------------------------------------------------------
`default_nettype none

module rod_cut_max_min_table #(
  parameter int PIECE_KINDS = 10,
  parameter int MAX_ROD     = 31
) (
  input  wire logic      clk,
  input  wire logic      rst,
  rcmm_item_if.sink      item,
  rcmm_result_if.source  result
);

  localparam int P_W    = $clog2(PIECE_KINDS + 1);
  localparam int DEPTH  = MAX_ROD + 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_AW = (PIECE_KINDS > 1) ? $clog2(PIECE_KINDS) : 1;
  localparam int CW     = rcmm_pkg::CMP_W;
  localparam int TW     = rcmm_pkg::TOTAL_W;
  localparam int SW     = TW + 1;
  localparam int PW     = rcmm_pkg::PRICE_W;
  localparam int RW     = rcmm_pkg::ROD_W;
  localparam int PCW    = rcmm_pkg::PIECE_W;

  // one table row: best totals and first pieces for one rod length
  typedef struct packed {
    logic [TW-1:0]  hi_tot;
    logic [TW-1:0]  lo_tot;
    logic [P_W-1:0] hi_ch;
    logic [P_W-1:0] lo_ch;
  } entry_t;

  localparam int WORD_W = 2 * TW + 2 * P_W;

  // sequencer: fill loop, then totals, then the two cut walks
  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_FILL_RD   = 6'b000010,
    S_FILL_WAIT = 6'b000100,
    S_TOT       = 6'b001000,
    S_CUT_RD    = 6'b010000,
    S_CUT_WAIT  = 6'b100000
  } state_t;

  state_t state;

  // price table, one entry per piece length
  logic [PW-1:0] price_table [PIECE_KINDS];

  // run control
  logic [ADDR_W-1:0] n;          // saturated rod length of this run
  logic [ADDR_W-1:0] len;        // length being filled
  logic [P_W-1:0]    p;          // candidate piece whose read is issued
  logic [P_W-1:0]    cand_p;     // candidate whose read data is back
  logic              cand_vld;
  logic              zero_r;     // candidate read hit length zero
  logic [ADDR_W-1:0] walk;       // remaining length during a cut walk
  logic              list_lo;    // walking the minimal cut

  // running best over candidates of the current length
  logic [SW-1:0]     acc_hi;
  logic [SW-1:0]     acc_lo;
  logic [P_W-1:0]    acc_hic;
  logic [P_W-1:0]    acc_loc;

  logic [TW-1:0]     tot_hi;
  logic [TW-1:0]     tot_lo;

  // output register
  logic                       res_valid;
  logic [rcmm_pkg::RKIND_W-1:0] res_kind;
  logic [TW-1:0]              res_max;
  logic [TW-1:0]              res_min;
  logic [PCW-1:0]             res_piece;
  logic                       res_last;

  // memory port signals
  logic              wr_en;
  entry_t            wr_word;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_bits;
  entry_t            rd_word;

  // datapath
  logic              item_xfer;
  logic              out_free;
  logic              res_load;
  logic [ADDR_W-1:0] n_sat;
  logic [CW-1:0]     limit_cw;
  logic              p_is_limit;
  logic [ADDR_W-1:0] rd_addr_fill;
  logic [PW-1:0]     price_sel;
  logic [TW-1:0]     base_hi;
  logic [TW-1:0]     base_lo;
  logic [SW-1:0]     cand_hi;
  logic [SW-1:0]     cand_lo;
  logic              first;
  logic              take_hi;
  logic              take_lo;
  logic [SW-1:0]     new_hi;
  logic [SW-1:0]     new_lo;
  logic [P_W-1:0]    new_hic;
  logic [P_W-1:0]    new_loc;
  logic [P_W-1:0]    ch_sel;
  logic [CW-1:0]     walk_cw;
  logic [CW-1:0]     ch_cw;
  logic [CW-1:0]     piece_cw;
  logic [CW-1:0]     walk_rem;

  // handshakes
  assign item.ready = (state == S_IDLE);
  assign item_xfer  = item.valid && item.ready;
  assign out_free   = !res_valid || result.ready;
  // a totals or piece transfer enters the output register this cycle
  assign res_load   = ((state == S_TOT) || (state == S_CUT_WAIT)) && out_free;

  assign result.valid        = res_valid;
  assign result.result_kind  = res_kind;
  assign result.max_total    = res_max;
  assign result.min_total    = res_min;
  assign result.piece_length = res_piece;
  assign result.last         = res_last;

  // rod lengths past the table saturate
  assign n_sat = (item.rod_length > RW'(MAX_ROD)) ? ADDR_W'(MAX_ROD)
                                                  : ADDR_W'(item.rod_length);

  // candidates run 1..min(len, PIECE_KINDS)
  assign limit_cw   = (CW'(len) < CW'(PIECE_KINDS)) ? CW'(len) : CW'(PIECE_KINDS);
  assign p_is_limit = (CW'(p) == limit_cw);
  assign rd_addr_fill = ADDR_W'(CW'(len) - CW'(p));

  assign rd_en   = (state == S_FILL_RD) || (state == S_CUT_RD);
  assign rd_addr = (state == S_CUT_RD) ? walk : rd_addr_fill;
  assign rd_word = entry_t'(rd_bits);

  // compare one candidate against the running best; ties keep the shorter
  assign price_sel = price_table[IDX_AW'(cand_p - P_W'(1))];
  assign base_hi   = zero_r ? '0 : rd_word.hi_tot;
  assign base_lo   = zero_r ? '0 : rd_word.lo_tot;
  assign cand_hi   = SW'(price_sel) + SW'(base_hi);
  assign cand_lo   = SW'(price_sel) + SW'(base_lo);
  assign first     = (cand_p == P_W'(1));
  assign take_hi   = first || (cand_hi > acc_hi);
  assign take_lo   = first || (cand_lo < acc_lo);
  assign new_hi    = take_hi ? cand_hi : acc_hi;
  assign new_hic   = take_hi ? cand_p  : acc_hic;
  assign new_lo    = take_lo ? cand_lo : acc_lo;
  assign new_loc   = take_lo ? cand_p  : acc_loc;

  // row write once the last candidate of a length is in
  assign wr_en          = (state == S_FILL_WAIT);
  assign wr_word.hi_tot = new_hi[TW-1:0];
  assign wr_word.lo_tot = new_lo[TW-1:0];
  assign wr_word.hi_ch  = new_hic;
  assign wr_word.lo_ch  = new_loc;

  // cut walk: a choice of zero or longer than the rest takes the rest
  assign ch_sel   = list_lo ? rd_word.lo_ch : rd_word.hi_ch;
  assign walk_cw  = CW'(walk);
  assign ch_cw    = CW'(ch_sel);
  assign piece_cw = ((ch_sel == '0) || (ch_cw > walk_cw)) ? walk_cw : ch_cw;
  assign walk_rem = walk_cw - piece_cw;

  rcmm_mem #(
    .DEPTH  (DEPTH),
    .WIDTH  (WORD_W),
    .ADDR_W (ADDR_W)
  ) u_tables (
    .clk   (clk),
    .we    (wr_en),
    .waddr (len),
    .wdata (wr_word),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_bits)
  );

  // price loads; out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIECE_KINDS; i++) begin
        price_table[i] <= '0;
      end
    end else if (item_xfer && (item.kind == rcmm_pkg::KIND_LOAD) &&
                 (CW'(item.piece_index) < CW'(PIECE_KINDS))) begin
      price_table[IDX_AW'(item.piece_index)] <= item.price_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cand_vld  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      cand_vld <= (state == S_FILL_RD);

      if (cand_vld) begin
        acc_hi  <= new_hi;
        acc_lo  <= new_lo;
        acc_hic <= new_hic;
        acc_loc <= new_loc;
      end

      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item_xfer && (item.kind == rcmm_pkg::KIND_RUN)) begin
            n      <= n_sat;
            tot_hi <= '0;
            tot_lo <= '0;
            len    <= ADDR_W'(1);
            p      <= P_W'(1);
            // a zero length rod only reports zero totals
            state  <= (n_sat == '0) ? S_TOT : S_FILL_RD;
          end
        end

        S_FILL_RD: begin
          cand_p <= p;
          zero_r <= (CW'(len) == CW'(p));
          if (p_is_limit) begin
            state <= S_FILL_WAIT;
          end else begin
            p <= p + P_W'(1);
          end
        end

        S_FILL_WAIT: begin
          // the idle read slot of this state keeps the next length off the row being written
          if (len == n) begin
            tot_hi <= new_hi[TW-1:0];
            tot_lo <= new_lo[TW-1:0];
            state  <= S_TOT;
          end else begin
            len   <= len + ADDR_W'(1);
            p     <= P_W'(1);
            state <= S_FILL_RD;
          end
        end

        S_TOT: begin
          if (out_free) begin
            res_kind  <= rcmm_pkg::RES_TOTALS;
            res_max   <= tot_hi;
            res_min   <= tot_lo;
            res_piece <= '0;
            res_last  <= (n == '0);
            walk      <= n;
            list_lo   <= 1'b0;
            state     <= (n == '0) ? S_IDLE : S_CUT_RD;
          end
        end

        S_CUT_RD: begin
          state <= S_CUT_WAIT;
        end

        S_CUT_WAIT: begin
          if (out_free) begin
            res_kind  <= list_lo ? rcmm_pkg::RES_MIN_PIECE : rcmm_pkg::RES_MAX_PIECE;
            res_max   <= '0;
            res_min   <= '0;
            res_piece <= piece_cw[PCW-1:0];
            res_last  <= list_lo && (walk_rem == '0);
            if (walk_rem == '0) begin
              if (list_lo) begin
                state <= S_IDLE;
              end else begin
                // maximal cut done, walk the minimal cut
                walk    <= n;
                list_lo <= 1'b1;
                state   <= S_CUT_RD;
              end
            end else begin
              walk  <= ADDR_W'(walk_rem);
              state <= S_CUT_RD;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* tb/rod_cut_max_min_table_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rod_cut_max_min_table_test
// self-checking bench for the rod cutting max/min table block: price loads and
// runs go in through a queue-fed driver, a clocked monitor predicts the totals
// and both cuts for every accepted run and checks each result transfer in order
// ----------------------------------------------------------------------------

module rod_cut_max_min_table_test;

  import rcmm_pkg::*;

  localparam int PIECE_KINDS = 10;
  localparam int MAX_ROD     = 31;

  // the limit covers the slowest runs, each with up to 63 results that may wait
  // out a receiver stall, for the roughly 130 items taken several times over
  localparam int CYCLE_LIMIT = 1000000;
  // quiet cycles after the last result; covers a full run of the block
  localparam int TAIL_CYCLES = 500;
  // receiver hold-off that forces the block to back up its input
  localparam int LONG_HOLD   = 600;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [IDX_W-1:0]   piece_index;
    logic [PRICE_W-1:0] price_value;
    logic [ROD_W-1:0]   rod_length;
  } rod_item_t;

  typedef struct {
    logic [RKIND_W-1:0] result_kind;
    logic [TOTAL_W-1:0] max_total;
    logic [TOTAL_W-1:0] min_total;
    logic [PIECE_W-1:0] piece_length;
    logic               last;
  } cut_result_t;

  logic clk = 1'b1;
  logic rst = 1'b1;

  rcmm_item_if   item_ch ();
  rcmm_result_if result_ch ();

  rod_cut_max_min_table #(
    .PIECE_KINDS (PIECE_KINDS),
    .MAX_ROD     (MAX_ROD)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b0;
    #10 clk = 1'b1;
  end

  // our own copy of the price table and the queue of results still owed
  logic [PRICE_W-1:0] price_book [PIECE_KINDS] = '{default: '0};
  cut_result_t        results_due [$];
  rod_item_t          items_to_send [$];

  int  items_queued    = 0;
  int  items_accepted  = 0;
  int  mismatches      = 0;
  int  cycle_count     = 0;
  bit  item_taken      = 1'b0;  // item transfer happened at the last rising edge
  bit  calm            = 1'b0;  // no idling on either side
  bit  hold_armed      = 1'b0;  // receiver should do its long hold-off
  bit  hold_done       = 1'b0;
  int  send_gap        = 0;
  int  ready_gap       = 0;
  int  hold_left       = 0;

  // --------------------------------------------------------------------------
  // prediction: a load updates the price copy, a run fills the best-high and
  // best-low tables bottom up and queues totals, the max cut, then the min cut
  // --------------------------------------------------------------------------
  task automatic solve_rod(input rod_item_t it);
    int n;
    int len;
    int p;
    int lim;
    int hi;
    int lo;
    int hic;
    int loc;
    int ch;
    int cl;
    int side;
    int rest;
    int piece;
    int high_best [MAX_ROD+1];
    int low_best  [MAX_ROD+1];
    int high_pick [MAX_ROD+1];
    int low_pick  [MAX_ROD+1];
    cut_result_t r;
    if (it.kind == KIND_LOAD) begin
      // out of range entries are dropped silently
      if (it.piece_index < PIECE_KINDS) begin
        price_book[it.piece_index] = it.price_value;
      end
    end else begin
      n = (int'(it.rod_length) > MAX_ROD) ? MAX_ROD : int'(it.rod_length);
      high_best[0] = 0;
      low_best[0]  = 0;
      for (len = 1; len <= n; len++) begin
        lim = (len < PIECE_KINDS) ? len : PIECE_KINDS;
        hi  = 0;
        lo  = 0;
        hic = 1;
        loc = 1;
        for (p = 1; p <= lim; p++) begin
          ch = price_book[p-1] + high_best[len-p];
          cl = price_book[p-1] + low_best[len-p];
          // strict compares keep the shortest first piece on a tie
          if (p == 1 || ch > hi) begin
            hi  = ch;
            hic = p;
          end
          if (p == 1 || cl < lo) begin
            lo  = cl;
            loc = p;
          end
        end
        high_best[len] = hi & 'h7FFF;
        low_best[len]  = lo & 'h7FFF;
        high_pick[len] = hic;
        low_pick[len]  = loc;
      end

      // a zero length rod ends with the totals alone
      r.result_kind  = RES_TOTALS;
      r.max_total    = TOTAL_W'(high_best[n]);
      r.min_total    = TOTAL_W'(low_best[n]);
      r.piece_length = '0;
      r.last         = (n == 0);
      results_due.insert(results_due.size(), r);

      // walk both choice tables back from n; only the min cut carries last
      for (side = 0; side < 2; side++) begin
        rest = n;
        while (rest > 0) begin
          piece = (side == 0) ? high_pick[rest] : low_pick[rest];
          rest  = rest - piece;
          r.result_kind  = (side == 0) ? RES_MAX_PIECE : RES_MIN_PIECE;
          r.max_total    = '0;
          r.min_total    = '0;
          r.piece_length = PIECE_W'(piece);
          r.last         = (side == 1 && rest == 0);
          results_due.insert(results_due.size(), r);
        end
      end
    end
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // --------------------------------------------------------------------------
  // monitor: samples both channels at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    cut_result_t want;
    rod_item_t   seen;
    item_taken <= !rst && item_ch.valid && item_ch.ready;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: result with nothing expected, actual kind %0d total %0d/%0d piece %0d",
                 $time, result_ch.result_kind, result_ch.max_total, result_ch.min_total,
                 result_ch.piece_length);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        check_field("result_kind",  int'(want.result_kind),  int'(result_ch.result_kind));
        check_field("max_total",    int'(want.max_total),    int'(result_ch.max_total));
        check_field("min_total",    int'(want.min_total),    int'(result_ch.min_total));
        check_field("piece_length", int'(want.piece_length), int'(result_ch.piece_length));
        check_field("last",         int'(want.last),         int'(result_ch.last));
      end
    end
    // results are handled first; a run's results can never come at its own edge
    if (!rst && item_ch.valid && item_ch.ready) begin
      seen.kind        = item_ch.kind;
      seen.piece_index = item_ch.piece_index;
      seen.price_value = item_ch.price_value;
      seen.rod_length  = item_ch.rod_length;
      solve_rod(seen);
      items_accepted <= items_accepted + 1;
    end
  end

  // --------------------------------------------------------------------------
  // driver: offers queued items at the falling edge, holds each until its
  // transfer, and sometimes idles for a burst after one
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_items
    rod_item_t outgoing;
    if (rst) begin
      item_ch.valid       <= 1'b0;
      item_ch.kind        <= KIND_LOAD;
      item_ch.piece_index <= '0;
      item_ch.price_value <= '0;
      item_ch.rod_length  <= '0;
    end else if (item_ch.valid && !item_taken) begin
      // still waiting for the block to take it
    end else if (send_gap > 0) begin
      item_ch.valid <= 1'b0;
      send_gap      <= send_gap - 1;
    end else if (items_to_send.size() > 0) begin
      outgoing = items_to_send.pop_front();
      item_ch.kind        <= outgoing.kind;
      item_ch.piece_index <= outgoing.piece_index;
      item_ch.price_value <= outgoing.price_value;
      item_ch.rod_length  <= outgoing.rod_length;
      item_ch.valid       <= 1'b1;
      if (!calm && $urandom_range(0, 4) == 0) begin
        send_gap <= $urandom_range(1, 12);
      end
    end else begin
      item_ch.valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random stall bursts, plus one long hold-off once armed so that
  // the block fills up while the driver keeps offering
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_ready
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      result_ch.ready <= 1'b0;
      hold_left       <= hold_left - 1;
    end else if (hold_armed && !hold_done) begin
      result_ch.ready <= 1'b0;
      hold_left       <= LONG_HOLD;
      hold_done       <= 1'b1;
    end else if (ready_gap > 0) begin
      result_ch.ready <= 1'b0;
      ready_gap       <= ready_gap - 1;
    end else begin
      result_ch.ready <= 1'b1;
      if (!calm && $urandom_range(0, 4) == 0) begin
        ready_gap <= $urandom_range(1, 12);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic queue_item(input logic [KIND_W-1:0] kind, input int idx, input int price,
                            input int len);
    rod_item_t it;
    it.kind        = kind;
    it.piece_index = IDX_W'(idx);
    it.price_value = PRICE_W'(price);
    it.rod_length  = ROD_W'(len);
    items_to_send.insert(items_to_send.size(), it);
    items_queued++;
  endtask

  // sender pause: nothing new until every transfer is done and nothing is owed
  task automatic drain();
    while (items_accepted != items_queued || results_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // well-formed groups: a few price loads, then a run with random content;
  // the odd load aims past the table and is ignored
  task automatic queue_random(input int target);
    int counted;
    int loads;
    int idx;
    int price;
    int len;
    counted = 0;
    while (counted < target) begin
      loads = $urandom_range(0, 3);
      repeat (loads) begin
        idx   = ($urandom_range(0, 99) < 85) ? $urandom_range(0, PIECE_KINDS - 1)
                                               : $urandom_range(PIECE_KINDS, 15);
        price = $urandom_range(0, 9);
        price = (price == 0) ? 0 : (price == 1) ? 1023 : $urandom_range(0, 1023);
        queue_item(KIND_LOAD, idx, price, $urandom_range(0, 31));
        counted++;
      end
      // mostly short rods keep runs quick; some go up to the longest
      len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 12) : $urandom_range(13, MAX_ROD);
      queue_item(KIND_RUN, $urandom_range(0, 15), $urandom_range(0, 1023), len);
      counted++;
    end
  endtask

  initial begin : stimulus
    int i;
    int start_price [PIECE_KINDS];
    start_price = '{3, 5, 8, 9, 10, 0, 17, 20, 24, 1023};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: runs on the all-zero table after reset, where every
    // candidate ties and the cut is all unit pieces
    queue_item(KIND_RUN, 15, 1023, 0);
    queue_item(KIND_RUN, 15, 1023, 3);
    // full table with a zero price and a top price, rod field at both ends
    for (i = 0; i < PIECE_KINDS; i++) begin
      queue_item(KIND_LOAD, i, start_price[i], (i % 2) ? 31 : 0);
    end
    // indexes past the table must leave it untouched
    queue_item(KIND_LOAD, PIECE_KINDS, 1023, 5);
    queue_item(KIND_LOAD, 15, 0, 31);
    queue_item(KIND_RUN, 0, 0, 1);
    queue_item(KIND_RUN, 9, 512, 10);
    queue_item(KIND_RUN, 9, 1023, MAX_ROD);
    // unit piece at top price gives the largest possible max total
    queue_item(KIND_LOAD, 0, 1023, 0);
    queue_item(KIND_LOAD, PIECE_KINDS - 1, 0, 0);
    queue_item(KIND_RUN, 6, 77, MAX_ROD);
    queue_item(KIND_RUN, 0, 1023, 17);
    drain();

    // random part with idling on both sides
    queue_random(50);
    drain();

    // long receiver hold-off while a long run and more items are offered
    queue_item(KIND_RUN, 3, 300, MAX_ROD);
    queue_random(30);
    hold_armed = 1'b1;
    drain();

    // last stretch at full rate
    calm = 1'b1;
    queue_random(28);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
